### rtl/core/ssst_pkg.sv
package ssst_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 7;
	localparam int STAT_W      = 2;
	localparam int MIN_FOR_SPAN = 2;

	localparam logic [VAL_W-1:0] SIGN_BIAS = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [STAT_W-1:0] ST_ADDED   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_CLEARED = 2'd2;

	// output tdata layout: count, shortest_span, longest_span, zero pad
	localparam int OD_CNT_LO   = 0;
	localparam int OD_SHORT_LO = OD_CNT_LO + CNT_W;
	localparam int OD_LONG_LO  = OD_SHORT_LO + VAL_W;
	localparam int OD_W        = ((OD_LONG_LO + VAL_W + 7) / 8) * 8;

	// output tuser layout: status, span_valid
	localparam int OU_VALID = STAT_W;
	localparam int OU_W     = STAT_W + 1;

	typedef struct packed {
		logic ins;
		logic occ;
		logic tail;
	} cell_ctl_t;

endpackage

### rtl/core/ssst_cell.sv
module ssst_cell import ssst_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [VAL_W-1:0] x,
	input  logic             lft_gt,
	input  logic [VAL_W-1:0] lft_val,
	output logic             gt,
	output logic [VAL_W-1:0] val
);

	logic [VAL_W-1:0] val_q;

	assign val = val_q;
	assign gt  = ctl.occ && (val_q > x);

	// shift right from the left neighbor or take the new value
	always_ff @(posedge clk) begin
		if (ctl.ins && (gt || ctl.tail)) begin
			val_q <= lft_gt ? lft_val : x;
		end
	end

endmodule

### rtl/core/sorted_store_span_tracker.sv
// channel | dir | handshake               | payload
// s_      | in  | s_tvalid / s_tready     | s_tdata value, s_tuser opcode
// m_      | out | m_tvalid / m_tready     | m_tdata count/spans, m_tuser status/span_valid
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_data capacity
// every transaction has the cell row compare and shift on the accept edge; the gap
// subtract and running minimum are formed in the calc state, which holds until the
// result register is free. one transaction is in flight at a time; a new one is taken
// while the result register still waits on m_tready. reset empties the store and sets
// capacity to 64. cfg_ready is always high.
module sorted_store_span_tracker import ssst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,  // value
	input  logic             s_tuser,  // opcode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OD_W-1:0]  m_tdata,  // count, shortest_span, longest_span, pad
	output logic [OU_W-1:0]  m_tuser,  // status, span_valid
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic             state_q;
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] min_gap_q;
	logic [VAL_W-1:0] max_q;
	logic [VAL_W-1:0] min_q;

	logic [VAL_W-1:0]  x_s1;
	logic [VAL_W-1:0]  left_s1;
	logic [VAL_W-1:0]  right_s1;
	logic              has_l_s1;
	logic              has_r_s1;
	logic              ins_s1;
	logic [STAT_W-1:0] status_s1;

	logic [OD_W-1:0] m_tdata_q;
	logic [OU_W-1:0] m_tuser_q;
	logic            m_tvalid_q;

	logic             acc;
	logic [VAL_W-1:0] xb;
	logic [CAP_W-1:0] limit;
	logic             full;
	logic             ins;
	logic             out_free;
	logic             load;

	logic             gt   [MAX_ENTRIES];
	logic [VAL_W-1:0] val  [MAX_ENTRIES];
	logic             occ  [MAX_ENTRIES];
	logic [VAL_W-1:0] left_or;
	logic [VAL_W-1:0] right_or;
	logic             has_l;
	logic             has_r;

	logic [VAL_W-1:0] gap_l;
	logic [VAL_W-1:0] gap_r;
	logic [VAL_W-1:0] min_new;
	logic             span_ok;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign xb        = s_tdata ^ SIGN_BIAS;
	assign limit     = (cap_q > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : cap_q;
	assign full      = (CAP_W'(count_q) >= limit);
	assign ins       = acc && (s_tuser == OP_ADD) && !full;
	assign out_free  = !m_tvalid_q || m_tready;
	assign load      = (state_q == ST_CALC) && out_free;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_ctl_t ctl;
		assign occ[i]   = (CNT_W'(i) < count_q);
		assign ctl.ins  = ins;
		assign ctl.occ  = occ[i];
		assign ctl.tail = (CNT_W'(i) == count_q);
		if (i == 0) begin : g_first
			ssst_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.x       (xb),
				.lft_gt  (1'b0),
				.lft_val ({VAL_W{1'b0}}),
				.gt      (gt[i]),
				.val     (val[i])
			);
		end else begin : g_rest
			ssst_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.x       (xb),
				.lft_gt  (gt[i-1]),
				.lft_val (val[i-1]),
				.gt      (gt[i]),
				.val     (val[i])
			);
		end
	end

	// pick the sorted neighbors of the new value from the row
	always_comb begin
		left_or  = '0;
		right_or = '0;
		has_l    = 1'b0;
		has_r    = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (occ[i] && !gt[i] && ((i == MAX_ENTRIES - 1) ||
			    !occ[(i + 1) % MAX_ENTRIES] || gt[(i + 1) % MAX_ENTRIES])) begin
				left_or = left_or | val[i];
				has_l   = 1'b1;
			end
			if (gt[i] && ((i == 0) || !gt[(i + MAX_ENTRIES - 1) % MAX_ENTRIES])) begin
				right_or = right_or | val[i];
				has_r    = 1'b1;
			end
		end
	end

	always_comb begin
		gap_l   = x_s1 - left_s1;
		gap_r   = right_s1 - x_s1;
		min_new = min_gap_q;
		if (ins_s1 && has_l_s1 && (gap_l < min_new)) begin
			min_new = gap_l;
		end
		if (ins_s1 && has_r_s1 && (gap_r < min_new)) begin
			min_new = gap_r;
		end
		span_ok = (count_q >= CNT_W'(MIN_FOR_SPAN));
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1      <= xb;
			left_s1   <= left_or;
			right_s1  <= right_or;
			has_l_s1  <= has_l;
			has_r_s1  <= has_r;
			status_s1 <= (s_tuser == OP_CLEAR) ? ST_CLEARED : (full ? ST_FULL : ST_ADDED);
		end
		if (ins) begin
			max_q <= ((count_q == '0) || (xb > max_q)) ? xb : max_q;
			min_q <= ((count_q == '0) || (xb < min_q)) ? xb : min_q;
		end
		if (load) begin
			m_tdata_q <= OD_W'({(span_ok ? (max_q - min_q) : {VAL_W{1'b0}}),
				(span_ok ? min_new : {VAL_W{1'b0}}), count_q});
			m_tuser_q <= {span_ok, status_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CAP_W'(MAX_ENTRIES);
			count_q    <= '0;
			min_gap_q  <= '1;
			ins_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (acc) begin
				state_q <= ST_CALC;
				ins_s1  <= ins;
				if (s_tuser == OP_CLEAR) begin
					count_q   <= '0;
					min_gap_q <= '1;
				end else if (ins) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (load) begin
				state_q    <= ST_IDLE;
				min_gap_q  <= min_new;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### rtl/core/ssst_checker.sv
module ssst_checker import ssst_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OD_W-1:0]  m_tdata,
	input logic [OU_W-1:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[STAT_W-1:0] == ST_CLEARED) |->
		(m_tdata[OD_CNT_LO +: CNT_W] == '0) && !m_tuser[OU_VALID])
		else $error("clear result not empty");

	a_span_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[OU_VALID] == (m_tdata[OD_CNT_LO +: CNT_W] >= CNT_W'(MIN_FOR_SPAN)))
		else $error("span_valid disagrees with count");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[OU_VALID] |->
		m_tdata[OD_SHORT_LO +: VAL_W] <= m_tdata[OD_LONG_LO +: VAL_W])
		else $error("shortest span above longest span");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[STAT_W-1:0] == ST_ADDED) || (m_tuser[STAT_W-1:0] == ST_FULL) ||
		(m_tuser[STAT_W-1:0] == ST_CLEARED))
		else $error("bad status code");

endmodule

bind sorted_store_span_tracker ssst_checker u_ssst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ssst_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_PHASES       = 10;
	localparam int PHASE_ITEMS    = 165;
	localparam int PRESSURE_AT    = 400;
	localparam int PRESSURE_LEN   = 300;

	typedef struct packed {
		logic             op;
		logic [VAL_W-1:0] value;
	} store_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
		logic              span_valid;
		logic [VAL_W-1:0]  shortest;
		logic [VAL_W-1:0]  longest;
	} span_report_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [VAL_W-1:0] s_tdata;  // value
	logic             s_tuser;  // opcode
	logic             m_tvalid;
	logic             m_tready;
	logic [OD_W-1:0]  m_tdata;  // count, shortest_span, longest_span, pad
	logic [OU_W-1:0]  m_tuser;  // status, span_valid
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	// shadow of the store, kept with the sign bit flipped so unsigned order is signed order
	logic [VAL_W-1:0] held_vals [MAX_ENTRIES];
	int               held_count;
	logic [VAL_W-1:0] gap_min;
	int               cap_shadow;

	store_item_t  item_q [$];
	span_report_t span_expect_q [$];
	span_report_t want;

	bit         failed;
	bit         no_idle;
	bit         src_taken;
	bit         pressure_done;
	int         src_gap;
	int         snk_gap;
	int         stall_left;
	int         src_idle_pct;
	int         snk_idle_pct;
	int         items_taken;
	int         stuck_cycles;
	logic [VAL_W-1:0] cluster_base;

	sorted_store_span_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic span_report_t span_after_item(store_item_t it);
		span_report_t     r;
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] g;
		int               pos;
		int               lim;
		b   = it.value ^ SIGN_BIAS;
		lim = (cap_shadow > MAX_ENTRIES) ? MAX_ENTRIES : cap_shadow;
		if (it.op == OP_CLEAR) begin
			held_count = 0;
			gap_min    = '1;
			r.status   = ST_CLEARED;
		end else if (held_count >= lim) begin
			r.status = ST_FULL;
		end else begin
			pos = held_count;
			while (pos > 0 && held_vals[pos-1] > b) begin
				held_vals[pos] = held_vals[pos-1];
				pos--;
			end
			held_vals[pos] = b;
			held_count++;
			if (pos > 0) begin
				g = b - held_vals[pos-1];
				if (g < gap_min)
					gap_min = g;
			end
			if (pos + 1 < held_count) begin
				g = held_vals[pos+1] - b;
				if (g < gap_min)
					gap_min = g;
			end
			r.status = ST_ADDED;
		end
		r.count      = CNT_W'(held_count);
		r.span_valid = held_count >= MIN_FOR_SPAN;
		r.shortest   = r.span_valid ? gap_min : '0;
		r.longest    = r.span_valid ? held_vals[held_count-1] - held_vals[0] : '0;
		return r;
	endfunction

	function automatic store_item_t mk_item(logic op, logic [VAL_W-1:0] value);
		store_item_t it;
		it.op    = op;
		it.value = value;
		return it;
	endfunction

	function automatic store_item_t gen_item(int clear_pct);
		store_item_t it;
		logic        hi;
		logic        lo;
		it.op = ($urandom_range(99) < clear_pct) ? OP_CLEAR : OP_ADD;
		hi    = 1'($urandom_range(1));
		lo    = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: it.value = $urandom;
			1: it.value = {hi, {(VAL_W-1){lo}}};
			2, 3, 4, 5: it.value = cluster_base + $urandom_range(40) - 20;
			default: begin
				it.value = $urandom >> $urandom_range(31);
				if (hi)
					it.value = -it.value;
			end
		endcase
		return it;
	endfunction

	task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failed = 1'b1;
		end
	endtask

	// write capacity while idle, queue the batch, then wait for the block to drain
	task automatic run_phase(int cap, store_item_t batch [$]);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap[CAP_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cap_shadow = cap;
		foreach (batch[i])
			item_q = {item_q, batch[i]};
		@(negedge clk);
		cfg_valid <= 1'b0;
		while (item_q.size() != 0 || span_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// source side
	always @(negedge clk) begin
		if (!(s_tvalid && !src_taken)) begin
			if (!no_idle && src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (item_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!no_idle && $urandom_range(99) < src_idle_pct) begin
				src_gap = $urandom_range(16);
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tuser  <= item_q[0].op;
				s_tdata  <= item_q[0].value;
			end
		end
		src_taken = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			span_expect_q = {span_expect_q, span_after_item(item_q.pop_front())};
			src_taken = 1'b1;
			items_taken++;
		end
	end

	// sink side, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!pressure_done && items_taken >= PRESSURE_AT) begin
			pressure_done = 1'b1;
			stall_left    = PRESSURE_LEN - 1;
			m_tready <= 1'b0;
		end else if (!no_idle && snk_gap > 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(99) < snk_idle_pct) begin
			snk_gap = $urandom_range(16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (span_expect_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				failed = 1'b1;
			end else begin
				want = span_expect_q.pop_front();
				check_field("status", VAL_W'(want.status), VAL_W'(m_tuser[STAT_W-1:0]));
				check_field("span_valid", VAL_W'(want.span_valid), VAL_W'(m_tuser[OU_VALID]));
				check_field("count", VAL_W'(want.count), VAL_W'(m_tdata[OD_CNT_LO +: CNT_W]));
				check_field("shortest_span", want.shortest, m_tdata[OD_SHORT_LO +: VAL_W]);
				check_field("longest_span", want.longest, m_tdata[OD_LONG_LO +: VAL_W]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_store_span_tracker: mismatch");
			$finish;
		end
	end

	initial begin
		store_item_t batch [$];
		int          caps [N_PHASES];
		int          clear_pcts [N_PHASES];
		caps       = '{2, 127, 0, 1, 5, 64, 3, 17, 100, 64};
		clear_pcts = '{12, 2, 10, 15, 10, 0, 6, 5, 2, 3};
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_ADD;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		held_count = 0;
		gap_min    = '1;
		cap_shadow = MAX_ENTRIES;
		src_idle_pct = 20;
		snk_idle_pct = 20;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes, duplicates, clears on a non-empty and an empty store
		batch = {batch, mk_item(OP_ADD, 32'h8000_0000)};
		batch = {batch, mk_item(OP_ADD, 32'h7FFF_FFFF)};
		batch = {batch, mk_item(OP_ADD, 32'h0000_0000)};
		batch = {batch, mk_item(OP_ADD, 32'h0000_0000)};
		batch = {batch, mk_item(OP_ADD, 32'hFFFF_FFFF)};
		batch = {batch, mk_item(OP_ADD, 32'h0000_0001)};
		batch = {batch, mk_item(OP_ADD, 32'h8000_0000)};
		batch = {batch, mk_item(OP_CLEAR, 32'hFFFF_FFFF)};
		batch = {batch, mk_item(OP_CLEAR, 32'h0000_0000)};
		batch = {batch, mk_item(OP_ADD, 32'h0000_0007)};
		batch = {batch, mk_item(OP_CLEAR, 32'hAAAA_AAAA)};
		batch = {batch, mk_item(OP_ADD, 32'hAAAA_AAAA)};
		batch = {batch, mk_item(OP_ADD, 32'h5555_5555)};
		batch = {batch, mk_item(OP_ADD, 32'h7FFF_FFFE)};
		batch = {batch, mk_item(OP_ADD, 32'h8000_0001)};
		batch = {batch, mk_item(OP_ADD, 32'hAAAA_AAAB)};
		batch = {batch, mk_item(OP_CLEAR, 32'h5555_5555)};
		run_phase(MAX_ENTRIES, batch);

		for (int p = 0; p < N_PHASES; p++) begin
			batch.delete();
			cluster_base = $urandom;
			no_idle = (p == N_PHASES - 1);
			case ($urandom_range(2))
				0: src_idle_pct = 0;
				1: src_idle_pct = 8;
				default: src_idle_pct = 30;
			endcase
			case ($urandom_range(2))
				0: snk_idle_pct = 0;
				1: snk_idle_pct = 8;
				default: snk_idle_pct = 30;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				batch = {batch, gen_item(clear_pcts[p])};
			run_phase(caps[p], batch);
		end

		repeat (10) @(posedge clk);
		if (!failed && span_expect_q.size() == 0)
			$display("sorted_store_span_tracker: match");
		else
			$display("sorted_store_span_tracker: mismatch");
		$finish;
	end

endmodule
